[hdl/mavg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, register codes and sequencer states of the moving average
// filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = $clog2(MAX_WINDOW * 65535 + 1);
  localparam int CNT_W      = $clog2(SUM_W);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic REG_WINDOW = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

[hdl/mavg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/mavg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_div
// Restoring divider, one quotient bit per cycle, for sum over window length.
// ----------------------------------------------------------------------------
module mavg_div
  import mavg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] rem;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   diff;
  logic             fits;

  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == '0)) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      count    <= CNT_W'(SUM_W - 1);
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      count    <= count - 1'b1;
      rem      <= fits ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      quotient <= {quotient[SUM_W-2:0], fits};
    end
  end

endmodule

[hdl/moving_average_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_filter_top
// Moving average over the last window_length samples, held in a ring.
// ----------------------------------------------------------------------------
// One average is returned for every sample. From transfer to result a sample
// passes through a ring read, a sum update, a divider start, the bit-serial
// divider that forms sum / window_length, a step that takes the quotient and
// the load of the output register. The input is ready again only after that,
// so a new sample is not taken before the last one is through, and a stalled
// output holds the next result, and with it the input, back for as long as
// the stall lasts. With window_length at zero the sample leaves the state
// untouched and goes straight to the finish state, which loads an average of
// zero; the input is ready again once that result is loaded. window_length
// sits at byte address 0; writes whose low 7 bits exceed 64 are ignored, and
// every accepted write clears the ring's valid flags, the sum and the write
// position. Write it only while no sample is in flight.
// ----------------------------------------------------------------------------
module moving_average_filter_top
  import mavg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // sample input stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // [15:0] sample
  // average output stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [15:0]        m_tdata,   // [15:0] average
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t state, state_next;

  logic [LEN_W-1:0]      window_length;
  logic [SAMPLE_W-1:0]   sample_reg;
  logic [SUM_W-1:0]      sum;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      pos_inc;
  logic [MAX_WINDOW-1:0] valid;
  logic [SAMPLE_W-1:0]   result;
  logic [SAMPLE_W-1:0]   ring_rdata;
  logic [SAMPLE_W-1:0]   old_sample;
  logic                  ring_we;
  logic                  div_start;
  logic                  div_done;
  logic [SUM_W-1:0]      quotient;
  logic                  s_xfer;
  logic                  out_free;
  logic                  cfg_write;
  logic [LEN_W-1:0]      cfg_len;

  assign pready    = 1'b1;
  assign cfg_len   = pwdata[LEN_W-1:0];
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW)
                     && (cfg_len <= LEN_W'(MAX_WINDOW));
  assign prdata    = (paddr[2] == REG_WINDOW) ? PDATA_W'(window_length) : '0;

  assign s_tready   = (state == ST_IDLE);
  assign s_xfer     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign ring_we    = (state == ST_UPDATE);
  assign div_start  = (state == ST_START);
  assign old_sample = valid[pos] ? ring_rdata : '0;
  assign pos_inc    = ((LEN_W'(pos) + 1'b1) >= window_length) ? '0 : pos + 1'b1;

  mavg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .addr  (pos),
    .wdata (sample_reg),
    .rdata (ring_rdata)
  );

  mavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (window_length),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          state_next = (window_length == '0) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_START;
      ST_START:  state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= '0;
      sum           <= '0;
      pos           <= '0;
      valid         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        window_length <= cfg_len;
        sum           <= '0;
        pos           <= '0;
        valid         <= '0;
      end else if (state == ST_UPDATE) begin
        sum        <= sum - SUM_W'(old_sample) + SUM_W'(sample_reg);
        pos        <= pos_inc;
        valid[pos] <= 1'b1;
      end
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (s_xfer) begin
      sample_reg <= s_tdata;
      result     <= '0;
    end else if (state == ST_DIVIDE && div_done) begin
      result <= quotient[SAMPLE_W-1:0];
    end
    if (state == ST_FINISH && out_free) begin
      m_tdata <= result;
    end
  end

endmodule

[hdl/mavg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_checker
// Port-level checks on the moving average filter, bound to the top level.
// ----------------------------------------------------------------------------
module mavg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic [1:0] pending;
  logic       s_xfer;
  logic       m_xfer;

  assign s_xfer = s_tvalid && s_tready;
  assign m_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s_xfer && !m_xfer) begin
      pending <= pending + 1'b1;
    end else if (m_xfer && !s_xfer) begin
      pending <= pending - 1'b1;
    end
  end

  // busy after every sample transfer
  assert property (@(posedge clk) disable iff (rst) s_xfer |=> !s_tready)
    else $error("accepted a sample while busy");

  // every result belongs to a sample
  assert property (@(posedge clk) disable iff (rst) m_xfer |-> (pending != 2'd0))
    else $error("result without a sample");

  assert property (@(posedge clk) disable iff (rst) m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind moving_average_filter_top mavg_checker u_mavg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the moving average filter.
// ----------------------------------------------------------------------------
// Samples are fed from a queue by a clocked driver. Each accepted sample runs
// through a local model of the ring and running sum, and the predicted average
// is queued. A clocked monitor checks every average against the oldest
// prediction. Window length is set over APB between drained phases and read
// back. Both stream sides idle at random. One phase holds the output off for
// a long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module tb;
  import mavg_pkg::*;

  localparam logic [PADDR_W-1:0] ADDR_WINDOW = PADDR_W'(REG_WINDOW) << 2;
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = PADDR_W'(4);
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 30;
  localparam int TARGET_ITEMS = 1450;

  typedef enum int {PAT_UNIFORM, PAT_FULL, PAT_ZERO, PAT_EDGES, PAT_LOW} pattern_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  moving_average_filter_top DUT (.*);

  always #5 clk = ~clk;

  // local model of the filter state
  logic [SAMPLE_W-1:0] win_ring [MAX_WINDOW];
  logic [POS_W-1:0]    win_pos = '0;
  logic [SUM_W-1:0]    win_sum = '0;
  logic [LEN_W-1:0]    win_len = '0;

  logic [15:0] sample_q[$];
  logic [15:0] avg_exp_q[$];

  int mismatches = 0;
  int sent = 0;
  int checked = 0;
  int pushed = 0;
  int window_writes = 0;
  int ignored_writes = 0;
  int min_len = MAX_WINDOW;
  int max_len = 0;
  bit idle_on = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int rx_next;
  int rx_hold = 0;
  int stuck = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int pick_wait();
    return idle_on ? $urandom_range(0, 4) : 0;
  endfunction

  function automatic void clear_window();
    foreach (win_ring[i]) win_ring[i] = '0;
    win_pos = '0;
    win_sum = '0;
  endfunction

  function automatic logic [15:0] next_average(input logic [15:0] smp);
    int unsigned p;
    logic [SUM_W-1:0] quo;
    if (win_len == 0) return '0;
    p = win_pos;
    if (p >= win_len) p = 0;
    win_sum = win_sum - win_ring[p] + smp;
    win_ring[p] = smp;
    p++;
    if (p >= win_len) p = 0;
    win_pos = POS_W'(p);
    quo = win_sum / win_len;
    return quo[15:0];
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        avg_exp_q.push_back(next_average(s_tdata));
        sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s_tdata <= sample_q.pop_front();
          s_tvalid <= 1'b1;
          tx_gap <= pick_wait();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // average monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
      rx_hold <= 0;
    end else begin
      rx_next = rx_wait;
      if (m_tvalid && m_tready) begin
        checked++;
        if (avg_exp_q.size() == 0)
          report_mismatch($sformatf("average %h with nothing expected", m_tdata));
        else if (m_tdata !== avg_exp_q[0])
          report_mismatch($sformatf("average %h, expected %h", m_tdata, avg_exp_q.pop_front()));
        else
          void'(avg_exp_q.pop_front());
        rx_next = pick_wait();
      end
      if (holds_served != hold_requests) begin
        holds_served <= hold_requests;
        rx_hold <= HOLD_CYCLES;
        rx_wait <= rx_next;
        m_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        rx_wait <= rx_next;
        m_tready <= 1'b0;
      end else if (rx_next > 0) begin
        rx_wait <= rx_next - 1;
        m_tready <= 1'b0;
      end else begin
        rx_wait <= 0;
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stuck <= 0;
    end else if (stuck >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("** moving_average_filter_top: FAILED **");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    data = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_window_reg();
    logic [PDATA_W-1:0] rd;
    apb_read(ADDR_WINDOW, rd);
    if (rd[LEN_W-1:0] !== win_len)
      report_mismatch($sformatf("window_length reads %0d, expected %0d", rd[LEN_W-1:0], win_len));
  endtask

  task automatic set_window(input logic [PDATA_W-1:0] data,
                            input logic [PADDR_W-1:0] addr = ADDR_WINDOW);
    apb_write(addr, data);
    window_writes++;
    if (addr == ADDR_WINDOW && data[LEN_W-1:0] <= MAX_WINDOW) begin
      win_len = data[LEN_W-1:0];
      clear_window();
      if (win_len < min_len) min_len = win_len;
      if (win_len > max_len) max_len = win_len;
    end else begin
      ignored_writes++;
    end
    check_window_reg();
  endtask

  task automatic push_sample(input logic [15:0] smp);
    sample_q.push_back(smp);
    pushed++;
  endtask

  task automatic push_pattern(input int count, input pattern_t pat);
    for (int i = 0; i < count; i++) begin
      case (pat)
        PAT_FULL:  push_sample(16'hFFFF);
        PAT_ZERO:  push_sample(16'h0000);
        PAT_EDGES: push_sample($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        PAT_LOW:   push_sample(16'($urandom_range(0, 15)));
        default:   push_sample(16'($urandom));
      endcase
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || avg_exp_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [PDATA_W-1:0] wdata;
    int sel;
    int wlen;
    pattern_t pat;

    clear_window();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // unconfigured after reset
    check_window_reg();
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h1234);
    drain();
    // window of one passes samples through
    set_window(32'd1);
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    push_sample(16'h8000);
    drain();
    // oversized and unknown-register writes leave everything alone
    set_window(32'd65);
    push_sample(16'h0007);
    drain();
    set_window(32'd127);
    set_window(32'd3, ADDR_UNUSED);
    push_sample(16'h0100);
    drain();
    set_window(MAX_WINDOW);
    repeat (4) push_sample(16'hFFFF);
    drain();
    set_window(32'd2);
    push_sample(16'hFFFF);
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    push_sample(16'h0000);
    drain();
    // zero window disables, a new window starts clean
    set_window(32'd0);
    push_sample(16'h0005);
    drain();
    set_window(32'd3);
    push_sample(16'h0009);
    drain();

    // full-scale window with wraparound
    set_window(MAX_WINDOW);
    push_pattern(2 * MAX_WINDOW + 12, PAT_FULL);
    drain();

    // long output hold while input keeps coming
    set_window(32'd8);
    idle_on = 1'b1;
    push_pattern(60, PAT_UNIFORM);
    hold_requests++;
    drain();

    while (pushed < TARGET_ITEMS) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       wlen = 1;
        1:       wlen = MAX_WINDOW;
        2:       wlen = 0;
        3:       wlen = $urandom_range(MAX_WINDOW + 1, 127);
        default: wlen = $urandom_range(1, MAX_WINDOW);
      endcase
      wdata = PDATA_W'(wlen);
      if ($urandom_range(0, 3) == 0)
        wdata = ($urandom & 32'hFFFF_FF80) | wdata;
      set_window(wdata);
      idle_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 9);
      pat = (sel < 5) ? PAT_UNIFORM : pattern_t'(sel - 4);
      if (pat > PAT_LOW) pat = PAT_EDGES;
      push_pattern($urandom_range(10, 100), pat);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (avg_exp_q.size() != 0)
      report_mismatch($sformatf("%0d averages never arrived", avg_exp_q.size()));
    $display("run covered %0d samples and %0d checked averages over %0d window writes",
             sent, checked, window_writes);
    $display("%0d writes ignored, window lengths from %0d to %0d, one %0d-cycle output hold",
             ignored_writes, min_len, max_len, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("** moving_average_filter_top: PASSED **");
    end else begin
      $display("** moving_average_filter_top: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mavg_pkg.sv
hdl/mavg_ram.sv
hdl/mavg_div.sv
hdl/moving_average_filter_top.sv
hdl/mavg_checker.sv
dv/tb.sv
